// ===== hw/rtl/bcc_pkg.sv =====
// shared types, constants and helper functions for the bit count and crc32c unit
package bcc_pkg;

  localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;
  localparam int          CHUNKS      = 4;
  localparam int          CHUNK_W     = 16;

  typedef enum logic [1:0] {
    MODE_POP = 2'd0,
    MODE_TZ  = 2'd1,
    MODE_LZ  = 2'd2,
    MODE_CRC = 2'd3
  } mode_t;

  typedef struct packed {
    logic [6:0] count;
    logic       cf;
    logic       zf;
  } count_res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC32C_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic [7:0] byte_mask(input logic [1:0] size_code);
    logic [7:0] m;
    unique case (size_code)
      2'd0: m = 8'h01;
      2'd1: m = 8'h03;
      2'd2: m = 8'h0F;
      2'd3: m = 8'hFF;
      default: m = 8'h01;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] pop16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      n = n + {4'd0, v[i]};
    end
    return n;
  endfunction

  function automatic logic [4:0] tz16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) begin
        n = 5'(i);
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lz16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        n = 5'(15 - i);
      end
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/bcc_crc_stage.sv =====
// one pipeline stage of the crc32c datapath, folds in up to two bytes
module bcc_crc_stage
  import bcc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] crc_in,
  input  logic [15:0] data,
  input  logic [1:0]  byte_en,
  output logic [31:0] crc_q
);

  logic [31:0] crc_lo;
  logic [31:0] crc_hi;

  always_comb begin
    crc_lo = byte_en[0] ? crc_byte(crc_in, data[7:0]) : crc_in;
    crc_hi = byte_en[1] ? crc_byte(crc_lo, data[15:8]) : crc_lo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crc_q <= crc_hi;
    end
  end

endmodule

// ===== hw/rtl/bcc_count_stage.sv =====
// two-stage popcount, trailing and leading zero count datapath
module bcc_count_stage
  import bcc_pkg::*;
(
  input  logic        clk,
  input  logic        en1,
  input  logic        en2,
  input  logic [63:0] operand,
  input  mode_t       mode_s1,
  output count_res_t  res_q
);

  logic [4:0]        pc [CHUNKS];
  logic [4:0]        tz [CHUNKS];
  logic [4:0]        lz [CHUNKS];
  logic [CHUNKS-1:0] nz;
  count_res_t        res_next;
  logic [6:0]        pop_sum;
  logic [6:0]        tz_sum;
  logic [6:0]        lz_sum;
  logic              all_zero;

  // per-chunk statistics
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < CHUNKS; k++) begin
        pc[k] <= pop16(operand[k*CHUNK_W +: CHUNK_W]);
        tz[k] <= tz16(operand[k*CHUNK_W +: CHUNK_W]);
        lz[k] <= lz16(operand[k*CHUNK_W +: CHUNK_W]);
        nz[k] <= |operand[k*CHUNK_W +: CHUNK_W];
      end
    end
  end

  always_comb begin
    all_zero = ~|nz;
    pop_sum  = {2'd0, pc[0]} + {2'd0, pc[1]} + {2'd0, pc[2]} + {2'd0, pc[3]};
    priority if (nz[0]) begin
      tz_sum = {2'd0, tz[0]};
    end else if (nz[1]) begin
      tz_sum = 7'd16 + {2'd0, tz[1]};
    end else if (nz[2]) begin
      tz_sum = 7'd32 + {2'd0, tz[2]};
    end else begin
      tz_sum = 7'd48 + {2'd0, tz[3]};
    end
    priority if (nz[3]) begin
      lz_sum = {2'd0, lz[3]};
    end else if (nz[2]) begin
      lz_sum = 7'd16 + {2'd0, lz[2]};
    end else if (nz[1]) begin
      lz_sum = 7'd32 + {2'd0, lz[1]};
    end else begin
      lz_sum = 7'd48 + {2'd0, lz[0]};
    end
    res_next = '0;
    unique case (mode_s1)
      MODE_POP: begin
        res_next.count = pop_sum;
        res_next.zf    = all_zero;
      end
      MODE_TZ: begin
        res_next.count = tz_sum;
        res_next.cf    = all_zero;
        res_next.zf    = (tz_sum == 7'd0);
      end
      MODE_LZ: begin
        res_next.count = lz_sum;
        res_next.cf    = all_zero;
        res_next.zf    = (lz_sum == 7'd0);
      end
      MODE_CRC: begin
        res_next = '0;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      res_q <= res_next;
    end
  end

endmodule

// ===== hw/rtl/bit_count_crc32c_unit.sv =====
// top level of the popcount, tzcnt, lzcnt and crc32c execution unit
// 4 register stages from input transaction to result valid; one transaction per cycle
// while the output is not stalled; crc folds two bytes per stage over all 4 stages
// counts are formed in stages 1 and 2 and carried through stages 3 and 4
// backpressure: a stage is ready when empty or when the stage after it moves
// reset: synchronous, clears the stage valid bits only
module bit_count_crc32c_unit
  import bcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // mode, operand, size_code, crc_seed, zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata    // result, carry_flag, zero_flag, flags_updated, zero pad
);

  mode_t       in_mode;
  logic [63:0] in_operand;
  logic [1:0]  in_size;
  logic [31:0] in_seed;
  logic [7:0]  in_mask;

  logic        v1, v2, v3, v4;
  logic        rdy1, rdy2, rdy3, rdy4;

  mode_t       mode1, mode2, mode3, mode4;
  logic [47:0] opnd1;
  logic [31:0] opnd2;
  logic [15:0] opnd3;
  logic [7:2]  mask1;
  logic [7:4]  mask2;
  logic [7:6]  mask3;
  logic [31:0] crc1, crc2, crc3, crc4;
  count_res_t  cnt2;
  count_res_t  cnt3;
  count_res_t  cnt4;

  logic [31:0] result;
  logic        flags_updated;

  assign in_mode    = mode_t'(s_tdata[1:0]);
  assign in_operand = s_tdata[65:2];
  assign in_size    = s_tdata[67:66];
  assign in_seed    = s_tdata[99:68];
  assign in_mask    = byte_mask(in_size);

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= s_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mode1 <= in_mode;
      opnd1 <= in_operand[63:16];
      mask1 <= in_mask[7:2];
    end
    if (rdy2) begin
      mode2 <= mode1;
      opnd2 <= opnd1[47:16];
      mask2 <= mask1[7:4];
    end
    if (rdy3) begin
      mode3 <= mode2;
      opnd3 <= opnd2[31:16];
      mask3 <= mask2[7:6];
      cnt3  <= cnt2;
    end
    if (rdy4) begin
      mode4 <= mode3;
      cnt4  <= cnt3;
    end
  end

  bcc_crc_stage u_crc1 (
    .clk     (clk),
    .en      (rdy1),
    .crc_in  (in_seed),
    .data    (in_operand[15:0]),
    .byte_en (in_mask[1:0]),
    .crc_q   (crc1)
  );

  bcc_crc_stage u_crc2 (
    .clk     (clk),
    .en      (rdy2),
    .crc_in  (crc1),
    .data    (opnd1[15:0]),
    .byte_en (mask1[3:2]),
    .crc_q   (crc2)
  );

  bcc_crc_stage u_crc3 (
    .clk     (clk),
    .en      (rdy3),
    .crc_in  (crc2),
    .data    (opnd2[15:0]),
    .byte_en (mask2[5:4]),
    .crc_q   (crc3)
  );

  bcc_crc_stage u_crc4 (
    .clk     (clk),
    .en      (rdy4),
    .crc_in  (crc3),
    .data    (opnd3),
    .byte_en (mask3),
    .crc_q   (crc4)
  );

  bcc_count_stage u_count (
    .clk     (clk),
    .en1     (rdy1),
    .en2     (rdy2),
    .operand (in_operand),
    .mode_s1 (mode1),
    .res_q   (cnt2)
  );

  assign flags_updated = (mode4 != MODE_CRC);
  assign result        = flags_updated ? {25'd0, cnt4.count} : crc4;

  assign m_tvalid = v4;
  assign m_tdata  = {5'd0, flags_updated, cnt4.zf, cnt4.cf, result};

`ifndef SYNTHESIS
  a_crc_flags_clear: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[34]) |-> (m_tdata[33:32] == 2'b00))
    else $error("crc result with flags set");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[34]) |-> (m_tdata[31:0] <= 32'd64))
    else $error("count result out of range");

  a_carry_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == 32'd64 && !m_tdata[33]))
    else $error("carry set without full count");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted transaction lost at first stage");
`endif

endmodule

// ===== dv/tb_bit_count_crc32c_unit.sv =====
// self-checking testbench for the popcount, tzcnt, lzcnt and crc32c execution unit
`timescale 1ns / 1ps

module tb_bit_count_crc32c_unit;
  import bcc_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 8;
  localparam int RANDOM_OPS  = 1100;

  typedef struct {
    mode_t       mode;
    logic [63:0] operand;
    logic [1:0]  size_code;
    logic [31:0] crc_seed;
    bit          hold_until_empty;
  } instr_t;

  typedef struct {
    logic [31:0] value;
    logic        cf;
    logic        zf;
    logic        upd;
  } outcome_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;  // mode, operand, size_code, crc_seed, zero pad
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;       // result, carry_flag, zero_flag, flags_updated, zero pad

  instr_t   instr_q[$];
  outcome_t outcome_q[$];
  instr_t   cur_instr;
  int       errors = 0;
  int       send_gap = 0;
  int       send_calm = 0;
  int       stall_left = 0;
  int       recv_calm = 0;
  int       idle_cycles = 0;

  bit_count_crc32c_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  function automatic outcome_t exec_bit_op(instr_t it);
    outcome_t    o;
    logic [31:0] crc;
    int          nbytes;
    o = '{value: 32'd0, cf: 1'b0, zf: 1'b0, upd: 1'b1};
    case (it.mode)
      MODE_POP: begin
        for (int i = 0; i < 64; i++) o.value += it.operand[i];
        o.zf = (it.operand == 64'd0);
      end
      MODE_TZ, MODE_LZ: begin
        o.value = 32'd64;
        if (it.mode == MODE_TZ) begin
          for (int i = 63; i >= 0; i--) if (it.operand[i]) o.value = i;
        end else begin
          for (int i = 0; i < 64; i++) if (it.operand[i]) o.value = 63 - i;
        end
        o.cf = (it.operand == 64'd0);
        o.zf = (o.value == 32'd0);
      end
      default: begin
        crc = it.crc_seed;
        nbytes = 1 << it.size_code;
        for (int k = 0; k < nbytes; k++) begin
          crc ^= {24'd0, it.operand[k*8 +: 8]};
          for (int b = 0; b < 8; b++) crc = (crc >> 1) ^ (crc[0] ? 32'h82F63B78 : 32'd0);
        end
        o.value = crc;
        o.upd = 1'b0;
      end
    endcase
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_instr(mode_t m, logic [63:0] opnd, logic [1:0] sz, logic [31:0] seed,
                             bit hold);
    instr_t it;
    it = '{mode: m, operand: opnd, size_code: sz, crc_seed: seed, hold_until_empty: hold};
    instr_q.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) outcome_q.push_back(exec_bit_op(cur_instr));
      if (s_tvalid && !s_tready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (instr_q.size() > 0 &&
                   !(instr_q[0].hold_until_empty && outcome_q.size() > 0)) begin
        cur_instr = instr_q.pop_front();
        s_tdata <= {4'd0, cur_instr.crc_seed, cur_instr.size_code, cur_instr.operand,
                    cur_instr.mode};
        s_tvalid <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (m_tdata[31:0] !== want.value) begin
            $display("%0t: result expected %h actual %h", $time, want.value, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[32] !== want.cf) begin
            $display("%0t: carry_flag expected %b actual %b", $time, want.cf, m_tdata[32]);
            errors++;
          end
          if (m_tdata[33] !== want.zf) begin
            $display("%0t: zero_flag expected %b actual %b", $time, want.zf, m_tdata[33]);
            errors++;
          end
          if (m_tdata[34] !== want.upd) begin
            $display("%0t: flags_updated expected %b actual %b", $time, want.upd,
                     m_tdata[34]);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
          if ($urandom_range(0, 99) == 0) recv_calm = $urandom_range(30, 100);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_bit_count_crc32c_unit: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0] opnd;
    mode_t       m;

    queue_instr(MODE_POP, 64'd0, 2'd3, 32'hFFFF_FFFF, 1'b0);
    queue_instr(MODE_POP, '1, 2'd0, 32'd0, 1'b0);
    queue_instr(MODE_POP, 64'h8000_0000_0000_0001, 2'd1, 32'h1234_5678, 1'b0);
    queue_instr(MODE_TZ, 64'd0, 2'd2, 32'hFFFF_FFFF, 1'b0);
    queue_instr(MODE_TZ, 64'd1, 2'd0, 32'd0, 1'b0);
    queue_instr(MODE_TZ, 64'h8000_0000_0000_0000, 2'd3, 32'd0, 1'b0);
    queue_instr(MODE_TZ, '1, 2'd1, 32'hA5A5_A5A5, 1'b0);
    queue_instr(MODE_TZ, 64'h0000_0001_0000_0000, 2'd0, 32'd0, 1'b0);
    queue_instr(MODE_LZ, 64'd0, 2'd1, 32'd0, 1'b0);
    queue_instr(MODE_LZ, 64'd1, 2'd3, 32'hFFFF_FFFF, 1'b0);
    queue_instr(MODE_LZ, 64'h8000_0000_0000_0000, 2'd2, 32'd0, 1'b0);
    queue_instr(MODE_LZ, '1, 2'd0, 32'd0, 1'b0);
    queue_instr(MODE_LZ, 64'h0000_0000_0001_0000, 2'd0, 32'd0, 1'b0);
    queue_instr(MODE_CRC, 64'd0, 2'd0, 32'd0, 1'b0);
    queue_instr(MODE_CRC, '1, 2'd0, 32'hFFFF_FFFF, 1'b0);
    queue_instr(MODE_CRC, '1, 2'd1, 32'hFFFF_FFFF, 1'b0);
    queue_instr(MODE_CRC, '1, 2'd2, 32'hFFFF_FFFF, 1'b0);
    queue_instr(MODE_CRC, '1, 2'd3, 32'hFFFF_FFFF, 1'b0);
    queue_instr(MODE_CRC, 64'h0123_4567_89AB_CDEF, 2'd3, 32'd0, 1'b0);
    queue_instr(MODE_CRC, 64'hFEDC_BA98_7654_3210, 2'd2, 32'h8000_0001, 1'b0);
    queue_instr(MODE_CRC, 64'h0000_0000_0000_0000, 2'd3, 32'hFFFF_FFFF, 1'b0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      m = mode_t'($urandom_range(0, 3));
      opnd = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: opnd = 64'd0;
        1: opnd = '1;
        2: opnd = 64'd1 << $urandom_range(0, 63);
        3: opnd = opnd << $urandom_range(0, 63);
        4: opnd = opnd >> $urandom_range(0, 63);
        5: opnd = (opnd << $urandom_range(0, 63)) >> $urandom_range(0, 63);
        default: begin
        end
      endcase
      queue_instr(m, opnd, 2'($urandom_range(0, 3)), $urandom, (n % 300) == 150);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (instr_q.size() != 0 || s_tvalid || outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && outcome_q.size() == 0) begin
      $display("tb_bit_count_crc32c_unit: clean");
    end else begin
      $display("tb_bit_count_crc32c_unit: errors");
    end
    $finish;
  end

endmodule

// ===== bit_count_crc32c_unit.f =====
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_crc_stage.sv
hw/rtl/bcc_count_stage.sv
hw/rtl/bit_count_crc32c_unit.sv
dv/tb_bit_count_crc32c_unit.sv
